/* sv/imu_lowpass_deadband_filter_top_assert.svh */
// assertion macros for the imu low-pass deadband filter
`ifndef IMU_LOWPASS_DEADBAND_FILTER_TOP_ASSERT_SVH
`define IMU_LOWPASS_DEADBAND_FILTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define ILPF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ILPF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ILPF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ILPF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/ilpf_pkg.sv */
// shared types, constants and helpers for the imu low-pass deadband filter
package ilpf_pkg;

    // fixed-point format of the filter state
    localparam int FRAC_BITS = 8;
    localparam int RAW_W     = 16;
    localparam int FIX_W     = 24;
    localparam int ALPHA_W   = 16;
    localparam int THR_W     = 23;

    // lane layout: three accel lanes then three gyro lanes
    localparam int NUM_LANES    = 6;
    localparam int NUM_ACCEL    = 3;
    localparam int ACCEL_Z_LANE = 2;

    // stream widths
    localparam int S_DATA_W = NUM_LANES * RAW_W;
    localparam int M_DATA_W = NUM_LANES * FIX_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_ALPHA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DEADBAND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_DEADBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_REF    = 3'd4;

    localparam logic [ALPHA_W-1:0] ACCEL_ALPHA_RST    = 16'd11796;
    localparam logic [ALPHA_W-1:0] GYRO_ALPHA_RST     = 16'd7864;
    localparam logic [THR_W-1:0]   ACCEL_DEADBAND_RST = 23'd18874;
    localparam logic [THR_W-1:0]   GYRO_DEADBAND_RST  = 23'd13107;
    localparam logic [FIX_W-1:0]   GRAVITY_REF_RST    = 24'd1048576;

    typedef logic signed [RAW_W-1:0] raw_t;
    typedef logic signed [FIX_W-1:0] fix_t;

    // per-lane control group from the top level
    typedef struct packed {
        logic               load;
        logic [ALPHA_W-1:0] alpha;
        logic [THR_W-1:0]   thr;
        fix_t               ref_val;
    } lane_cfg_t;

    localparam logic signed [31:0] FIX_MAX = 32'sd8388607;
    localparam logic signed [31:0] FIX_MIN = -32'sd8388608;

    // clamp a 32-bit signed value to the 24-bit state range
    function automatic fix_t sat_fix(input logic signed [31:0] v);
        fix_t r;
        if (v > FIX_MAX) begin
            r = FIX_MAX[FIX_W-1:0];
        end else if (v < FIX_MIN) begin
            r = FIX_MIN[FIX_W-1:0];
        end else begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/ilpf_lane.sv */
// one filter channel: state register, low-pass update and deadband snap
module ilpf_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  ilpf_pkg::raw_t      raw,
    input  ilpf_pkg::lane_cfg_t cfg,
    output ilpf_pkg::fix_t      result
);
    import ilpf_pkg::*;

    fix_t                st_reg;
    fix_t                st_next;
    logic signed [31:0]  tgt_wide;
    fix_t                target;
    logic signed [24:0]  diff;
    logic signed [41:0]  prod;
    logic signed [25:0]  step;
    logic signed [26:0]  sum;
    fix_t                upd;
    fix_t                pre;
    logic signed [24:0]  dev;
    logic [24:0]         mag;
    logic                snap;

    // widen the raw count to the fixed-point target
    assign tgt_wide = {{(32-RAW_W){raw[RAW_W-1]}}, raw} <<< FRAC_BITS;
    assign target   = sat_fix(tgt_wide);

    // state += floor((target - state) * alpha / 65536)
    always_comb begin
        diff = {target[FIX_W-1], target} - {st_reg[FIX_W-1], st_reg};
        prod = diff * $signed({1'b0, cfg.alpha});
        step = prod[41:16];
        sum  = {{3{st_reg[FIX_W-1]}}, st_reg} + {step[25], step};
        upd  = sat_fix({{5{sum[26]}}, sum});
        pre  = cfg.load ? target : upd;
    end

    // deadband around the lane reference
    always_comb begin
        dev     = {pre[FIX_W-1], pre} - {cfg.ref_val[FIX_W-1], cfg.ref_val};
        mag     = dev[24] ? 25'(-dev) : 25'(dev);
        snap    = (mag < {2'b00, cfg.thr});
        st_next = snap ? cfg.ref_val : pre;
    end

    assign result = st_next;

    // state update on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

endmodule

/* sv/ilpf_merge.sv */
// gathers the lane results into one output beat held in a register
module ilpf_merge (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  take,
    input  ilpf_pkg::fix_t [ilpf_pkg::NUM_LANES-1:0] lanes,
    output logic                                  can_take,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ilpf_pkg::M_DATA_W-1:0]         m_tdata
);
    import ilpf_pkg::*;

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;
    logic [M_DATA_W-1:0] data_next;

    // pack lane 0 into the lowest bits
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            data_next[i*FIX_W +: FIX_W] = lanes[i];
        end
    end

    // register free when empty or being drained this cycle
    assign can_take = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_take) begin
            valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && can_take) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

/* sv/imu_lowpass_deadband_filter_top.sv */
// imu six-channel low-pass filter with deadband, top level
// a result beat appears in the cycle after its sample beat is accepted
// throughput: one sample per cycle while the output register is empty or being drained
// six lanes run side by side, the output register holds the packed results
// reset: synchronous active-low aresetn clears state, primed flag and output
// valid, and loads the default alphas, deadbands and gravity reference
module imu_lowpass_deadband_filter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // accel x, accel y, accel z, gyro x, gyro y, gyro z counts
    input  logic [ilpf_pkg::S_DATA_W-1:0]       s_tdata,
    // restart
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out
    output logic [ilpf_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ilpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ilpf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ilpf_pkg::*;

`include "imu_lowpass_deadband_filter_top_assert.svh"

    logic [ALPHA_W-1:0] accel_alpha_reg;
    logic [ALPHA_W-1:0] gyro_alpha_reg;
    logic [THR_W-1:0]   accel_db_reg;
    logic [THR_W-1:0]   gyro_db_reg;
    fix_t               grav_ref_reg;
    logic               primed_reg;
    logic               s_beat;
    logic               load;
    lane_cfg_t          lane_cfg [NUM_LANES];
    fix_t [NUM_LANES-1:0] lane_res;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_alpha_reg <= ACCEL_ALPHA_RST;
            gyro_alpha_reg  <= GYRO_ALPHA_RST;
            accel_db_reg    <= ACCEL_DEADBAND_RST;
            gyro_db_reg     <= GYRO_DEADBAND_RST;
            grav_ref_reg    <= GRAVITY_REF_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACCEL_ALPHA:    accel_alpha_reg <= cfg_data[ALPHA_W-1:0];
                REG_GYRO_ALPHA:     gyro_alpha_reg  <= cfg_data[ALPHA_W-1:0];
                REG_ACCEL_DEADBAND: accel_db_reg    <= cfg_data[THR_W-1:0];
                REG_GYRO_DEADBAND:  gyro_db_reg     <= cfg_data[THR_W-1:0];
                REG_GRAVITY_REF:    grav_ref_reg    <= cfg_data[FIX_W-1:0];
                default: ;
            endcase
        end
    end

    // first sample, or a restart, loads the state directly
    assign s_beat = s_tvalid && s_tready;
    assign load   = !primed_reg || s_tuser;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (s_beat) begin
            primed_reg <= 1'b1;
        end
    end

    // per-lane weight, threshold and reference
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_cfg[i].load    = load;
            lane_cfg[i].alpha   = (i < NUM_ACCEL) ? accel_alpha_reg : gyro_alpha_reg;
            lane_cfg[i].thr     = (i < NUM_ACCEL) ? accel_db_reg : gyro_db_reg;
            lane_cfg[i].ref_val = (i == ACCEL_Z_LANE) ? grav_ref_reg : '0;
        end
    end

    // filter lanes
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        ilpf_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (s_beat),
            .raw     (s_tdata[g*RAW_W +: RAW_W]),
            .cfg     (lane_cfg[g]),
            .result  (lane_res[g])
        );
    end

    // output register
    ilpf_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (s_beat),
        .lanes    (lane_res),
        .can_take (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // every accepted sample yields a pending result next cycle
    `ILPF_ASSERT_NXT(a_beat_gives_result, aclk, aresetn, s_beat, m_tvalid)
    // an accepted sample leaves the filter primed
    `ILPF_ASSERT_NXT(a_beat_primes, aclk, aresetn, s_beat, primed_reg)
    // an empty output register never stalls the input side
    `ILPF_ASSERT_IMP(a_empty_ready, aclk, aresetn, !m_tvalid, s_tready)

endmodule
